// File: hdl/modular_exponentiation_macros.svh
// Assertion helpers for the modular exponentiation block.
`ifndef MODULAR_EXPONENTIATION_MACROS_SVH
`define MODULAR_EXPONENTIATION_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define MEXP_ASSERT_NOW(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: check failed");

// Next-cycle implication, disabled in reset.
`define MEXP_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

// File: hdl/mexp_pkg.sv
`default_nettype none
package mexp_pkg;

  localparam int RES_W = 30;
  localparam int IN_W  = 64;
  localparam int E_W   = 63;
  localparam int CNT_W = 6;

  localparam logic [RES_W-1:0] MODULUS = RES_W'(998244353);
  localparam logic [RES_W-1:0] MOD_M1  = RES_W'(998244352);
  localparam logic [31:0]      MOD_X2  = 32'(2 * 998244353);
  localparam logic [31:0]      MOD_M1_X2 = 32'(2 * 998244352);

  // Barrett constant floor(2^60 / MODULUS)
  localparam logic [30:0] MU = 31'((64'd1 << 60) / 64'd998244353);
  // Barrett constant floor(2^60 / MOD_M1)
  localparam logic [30:0] MU_E = 31'((64'd1 << 60) / 64'd998244352);

  // 2^32 mod each modulus, for folding the upper word
  localparam logic [28:0] FOLD_B = 29'((64'd1 << 32) % 64'd998244353);
  localparam logic [28:0] FOLD_E = 29'((64'd1 << 32) % 64'd998244352);

  localparam int MUL_LAT = 5;
  localparam int RED_LAT = 6;
  localparam logic [CNT_W-1:0] RED_LAST  = CNT_W'(RED_LAT - 1);
  localparam logic [CNT_W-1:0] WAIT_LAST = CNT_W'(MUL_LAT - 2);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_SETUP,
    ST_CHECK,
    ST_WAIT,
    ST_UPDATE,
    ST_DONE
  } mexp_state_t;

  typedef struct packed {
    logic load;
    logic reduce;
    logic setup;
    logic update;
    logic finish;
  } mexp_cmd_t;

  typedef struct packed {
    logic in_exp_zero;
    logic e_zero;
  } mexp_status_t;

endpackage
`default_nettype wire

// File: hdl/modular_exponentiation.sv
// A zero exponent skips the reduction and the multiply loop; otherwise the block
// runs a folded Barrett reduction of base and exponent, then one loop step per
// bit of the exponent used (bit length at most 63), each step a multiply through
// the 5-stage Barrett multipliers. One request in flight: the next is taken
// once the result is registered, and a new result waits while the previous one
// is not yet taken. Sync reset clears control only.
`default_nettype none
`include "modular_exponentiation_macros.svh"
module modular_exponentiation
  import mexp_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [IN_W-1:0]  base,
  input  wire logic [IN_W-1:0]  exponent,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic      [RES_W-1:0] power,
  output logic                  not_invertible
);

  mexp_cmd_t    cmd;
  mexp_status_t status;

  mexp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  mexp_datapath u_dp (
    .clk            (clk),
    .base           (base),
    .exponent       (exponent),
    .cmd            (cmd),
    .status         (status),
    .power          (power),
    .not_invertible (not_invertible)
  );

  `MEXP_ASSERT_NOW(a_power_range, clk, rst, out_valid, power < MODULUS)
  `MEXP_ASSERT_NOW(a_noinv_zero, clk, rst, out_valid && not_invertible, power == '0)
  `MEXP_ASSERT_NEXT(a_busy_after_req, clk, rst, in_valid && in_ready, !in_ready)

endmodule
`default_nettype wire

// File: hdl/mexp_mulmod.sv
`default_nettype none
// a*b mod MODULUS, Barrett reduction, operands held stable
module mexp_mulmod
  import mexp_pkg::*;
(
  input  wire logic             clk,
  input  wire logic [RES_W-1:0] a,
  input  wire logic [RES_W-1:0] b,
  output logic      [RES_W-1:0] r
);

  logic [59:0] prod;
  logic [61:0] q2;
  logic [31:0] x2;
  logic [31:0] x3;
  logic [31:0] qm;
  logic [31:0] r4;
  logic [30:0] q3;

  assign q3 = q2[61:31];

  always_ff @(posedge clk) begin
    prod <= 60'(a) * 60'(b);
    q2   <= 62'(prod[59:29]) * 62'(MU);
    x2   <= prod[31:0];
    qm   <= 32'(61'(q3) * 61'(MODULUS));
    x3   <= x2;
    r4   <= x3 - qm;
    if (r4 >= MOD_X2) begin
      r <= RES_W'(r4 - MOD_X2);
    end else if (r4 >= 32'(MODULUS)) begin
      r <= RES_W'(r4 - 32'(MODULUS));
    end else begin
      r <= RES_W'(r4);
    end
  end

endmodule
`default_nettype wire

// File: hdl/mexp_datapath.sv
`default_nettype none
module mexp_datapath
  import mexp_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic [IN_W-1:0]        base,
  input  wire logic [IN_W-1:0]        exponent,
  input  wire mexp_cmd_t              cmd,
  output mexp_status_t                status,
  output logic        [RES_W-1:0]     power,
  output logic                        not_invertible
);

  logic [IN_W-1:0]  base_mag;
  logic [IN_W-1:0]  exp_mag;
  logic             base_neg;
  logic             exp_neg;
  logic [61:0]      fold_b;
  logic [61:0]      fold_e;
  logic [59:0]      near_b;
  logic [59:0]      near_e;
  logic [61:0]      qt_b;
  logic [61:0]      qt_e;
  logic [31:0]      lo_b;
  logic [31:0]      lo_e;
  logic [31:0]      qm_b;
  logic [31:0]      qm_e;
  logic [31:0]      lo2_b;
  logic [31:0]      lo2_e;
  logic [31:0]      diff_b;
  logic [31:0]      diff_e;
  logic [RES_W-1:0] rem_b;
  logic [RES_W-1:0] rem_e;
  logic [RES_W-1:0] b;
  logic [RES_W-1:0] acc;
  logic [E_W-1:0]   e;
  logic             flag;
  logic [RES_W-1:0] b_red;
  logic [RES_W-1:0] mm_acc;
  logic [RES_W-1:0] mm_sq;

  function automatic logic [RES_W-1:0] fix_rem(
    input logic [31:0]      x,
    input logic [RES_W-1:0] m,
    input logic [31:0]      m2
  );
    logic [31:0] t;
    t = x;
    if (t >= m2) begin
      t = t - m2;
    end else if (t >= 32'(m)) begin
      t = t - 32'(m);
    end
    return t[RES_W-1:0];
  endfunction

  assign status.in_exp_zero = (exponent == '0);
  assign status.e_zero      = (e == '0);

  assign b_red = (base_neg && rem_b != '0) ? MODULUS - rem_b : rem_b;

  mexp_mulmod u_mul_acc (.clk(clk), .a(acc), .b(b), .r(mm_acc));
  mexp_mulmod u_mul_sq  (.clk(clk), .a(b),   .b(b), .r(mm_sq));

  // magnitude reduction: fold the upper word twice, then Barrett; RED_LAT stages
  always_ff @(posedge clk) begin
    if (cmd.reduce) begin
      fold_b <= 62'(base_mag[63:32]) * 62'(FOLD_B) + 62'(base_mag[31:0]);
      near_b <= 60'(fold_b[61:32]) * 60'(FOLD_B) + 60'(fold_b[31:0]);
      qt_b   <= 62'(near_b[59:29]) * 62'(MU);
      lo_b   <= near_b[31:0];
      qm_b   <= 32'(61'(qt_b[61:31]) * 61'(MODULUS));
      lo2_b  <= lo_b;
      diff_b <= lo2_b - qm_b;
      rem_b  <= fix_rem(diff_b, MODULUS, MOD_X2);

      fold_e <= 62'(exp_mag[63:32]) * 62'(FOLD_E) + 62'(exp_mag[31:0]);
      near_e <= 60'(fold_e[61:32]) * 60'(FOLD_E) + 60'(fold_e[31:0]);
      qt_e   <= 62'(near_e[59:29]) * 62'(MU_E);
      lo_e   <= near_e[31:0];
      qm_e   <= 32'(61'(qt_e[61:31]) * 61'(MOD_M1));
      lo2_e  <= lo_e;
      diff_e <= lo2_e - qm_e;
      rem_e  <= fix_rem(diff_e, MOD_M1, MOD_M1_X2);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      base_neg <= base[IN_W-1];
      exp_neg  <= exponent[IN_W-1];
      base_mag <= base[IN_W-1] ? IN_W'(0) - base : base;
      exp_mag  <= exponent[IN_W-1] ? IN_W'(0) - exponent : exponent;
      acc      <= RES_W'(1);
      e        <= exponent[E_W-1:0];
      flag     <= 1'b0;
    end
    if (cmd.setup) begin
      b <= b_red;
      if (exp_neg) begin
        if (b_red == '0) begin
          flag <= 1'b1;
          acc  <= '0;
          e    <= '0;
        end else begin
          e <= E_W'(MOD_M1 - rem_e);
        end
      end
    end
    if (cmd.update) begin
      if (e[0]) begin
        acc <= mm_acc;
      end
      b <= mm_sq;
      e <= e >> 1;
    end
    if (cmd.finish) begin
      power          <= acc;
      not_invertible <= flag;
    end
  end

endmodule
`default_nettype wire

// File: hdl/mexp_ctrl.sv
`default_nettype none
module mexp_ctrl
  import mexp_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  wire logic         out_ready,
  input  wire mexp_status_t status,
  output mexp_cmd_t         cmd
);

  mexp_state_t      state;
  mexp_state_t      state_next;
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] cnt_next;
  logic             out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          cnt_next   = '0;
          state_next = status.in_exp_zero ? ST_CHECK : ST_REDUCE;
        end
      end
      ST_REDUCE: begin
        cmd.reduce = 1'b1;
        cnt_next   = cnt + CNT_W'(1);
        if (cnt == RED_LAST) begin
          state_next = ST_SETUP;
        end
      end
      ST_SETUP: begin
        cmd.setup  = 1'b1;
        state_next = ST_CHECK;
      end
      ST_CHECK: begin
        cnt_next   = '0;
        state_next = status.e_zero ? ST_DONE : ST_WAIT;
      end
      ST_WAIT: begin
        cnt_next = cnt + CNT_W'(1);
        if (cnt == WAIT_LAST) begin
          state_next = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        cmd.update = 1'b1;
        state_next = ST_CHECK;
      end
      ST_DONE: begin
        if (!out_valid || out_ready) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.finish) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

endmodule
`default_nettype wire
